>>> rtl/c8d_pkg.sv
// Shared types and constants for the CHIP-8 ROM instruction decoder.
`default_nettype none

package c8d_pkg;

   localparam logic [15:0] BASE_RESET = 16'h0200;
   localparam logic [15:0] OFFSET_STEP = 16'd2;

   localparam logic [5:0] KIND_SYS        = 6'd0;
   localparam logic [5:0] KIND_CLS        = 6'd1;
   localparam logic [5:0] KIND_RET        = 6'd2;
   localparam logic [5:0] KIND_JP         = 6'd3;
   localparam logic [5:0] KIND_CALL       = 6'd4;
   localparam logic [5:0] KIND_JP_V0      = 6'd5;
   localparam logic [5:0] KIND_SE_VX_NN   = 6'd6;
   localparam logic [5:0] KIND_SNE_VX_NN  = 6'd7;
   localparam logic [5:0] KIND_SE_VX_VY   = 6'd8;
   localparam logic [5:0] KIND_SNE_VX_VY  = 6'd9;
   localparam logic [5:0] KIND_SKP        = 6'd10;
   localparam logic [5:0] KIND_SKNP       = 6'd11;
   localparam logic [5:0] KIND_LD_VX_NN   = 6'd12;
   localparam logic [5:0] KIND_LD_VX_VY   = 6'd13;
   localparam logic [5:0] KIND_LD_I_NNN   = 6'd14;
   localparam logic [5:0] KIND_LD_VX_DT   = 6'd15;
   localparam logic [5:0] KIND_LD_VX_K    = 6'd16;
   localparam logic [5:0] KIND_LD_DT_VX   = 6'd17;
   localparam logic [5:0] KIND_LD_ST_VX   = 6'd18;
   localparam logic [5:0] KIND_LD_F_VX    = 6'd19;
   localparam logic [5:0] KIND_LD_B_VX    = 6'd20;
   localparam logic [5:0] KIND_LD_I_VX    = 6'd21;
   localparam logic [5:0] KIND_LD_VX_I    = 6'd22;
   localparam logic [5:0] KIND_ADD_VX_NN  = 6'd23;
   localparam logic [5:0] KIND_ADD_VX_VY  = 6'd24;
   localparam logic [5:0] KIND_ADD_I_VX   = 6'd25;
   localparam logic [5:0] KIND_SUB_VX_VY  = 6'd26;
   localparam logic [5:0] KIND_SUBN_VX_VY = 6'd27;
   localparam logic [5:0] KIND_OR_VX_VY   = 6'd28;
   localparam logic [5:0] KIND_AND_VX_VY  = 6'd29;
   localparam logic [5:0] KIND_XOR_VX_VY  = 6'd30;
   localparam logic [5:0] KIND_SHR_VX     = 6'd31;
   localparam logic [5:0] KIND_SHL_VX     = 6'd32;
   localparam logic [5:0] KIND_RND        = 6'd33;
   localparam logic [5:0] KIND_DRW        = 6'd34;
   localparam logic [5:0] KIND_UNKNOWN    = 6'd35;

   typedef struct packed {
      logic [15:0] address;
      logic [15:0] opcode;
   } pair_type;

   typedef struct packed {
      logic [15:0] instr_address;
      logic [15:0] opcode_word;
      logic [3:0]  reg_x;
      logic [3:0]  reg_y;
      logic [3:0]  nibble_n;
      logic [7:0]  byte_nn;
      logic [11:0] addr_nnn;
      logic [5:0]  instr_kind;
      logic        is_jump;
      logic        is_skip;
      logic        is_call;
      logic        is_ret;
   } decoded_type;

endpackage

`default_nettype wire

>>> rtl/chip8_rom_instruction_decoder_top.sv
// Top level of the CHIP-8 ROM instruction decoder with its result register.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_rom_byte, req_rom_end
//   rsp     | out       | rsp_valid / rsp_stall | address, opcode, fields, kind, flags
//   csr     | in        | csr_wr_en             | csr_wr_data (base address)
//
// One ROM byte is accepted per cycle while req_stall is low; each completed byte
// pair yields one result beat, and an end byte that opens a pair yields none. A result
// passes through the pairing register, the decode logic and the result register.
// Reset clears pairing state, the byte offset and both valid flags, and sets
// the base address to 0x200. A stalled result holds in place; the pairing
// register stays free to take bytes while the result register can move.
`default_nettype none

module chip8_rom_instruction_decoder_top
   import c8d_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rom_byte,
   input  wire logic        req_rom_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_instr_address,
   output logic [15:0]      rsp_opcode_word,
   output logic [3:0]       rsp_reg_x,
   output logic [3:0]       rsp_reg_y,
   output logic [3:0]       rsp_nibble_n,
   output logic [7:0]       rsp_byte_nn,
   output logic [11:0]      rsp_addr_nnn,
   output logic [5:0]       rsp_instr_kind,
   output logic             rsp_is_jump,
   output logic             rsp_is_skip,
   output logic             rsp_is_call,
   output logic             rsp_is_ret
);

   logic        pair_valid;
   pair_type    pair;
   decoded_type dec;
   decoded_type rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_open;

   assign rsp_open = !rsp_valid_ff || !rsp_stall;

   c8d_pair u_pair (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rom_byte (req_rom_byte),
      .req_rom_end  (req_rom_end),
      .down_open    (rsp_open),
      .pair_valid   (pair_valid),
      .pair         (pair)
   );

   c8d_decode u_decode (
      .pair (pair),
      .dec  (dec)
   );

   assign rsp_valid_in = rsp_open ? pair_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_open && pair_valid) begin
         rsp_ff <= dec;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_instr_address = rsp_ff.instr_address;
   assign rsp_opcode_word   = rsp_ff.opcode_word;
   assign rsp_reg_x         = rsp_ff.reg_x;
   assign rsp_reg_y         = rsp_ff.reg_y;
   assign rsp_nibble_n      = rsp_ff.nibble_n;
   assign rsp_byte_nn       = rsp_ff.byte_nn;
   assign rsp_addr_nnn      = rsp_ff.addr_nnn;
   assign rsp_instr_kind    = rsp_ff.instr_kind;
   assign rsp_is_jump       = rsp_ff.is_jump;
   assign rsp_is_skip       = rsp_ff.is_skip;
   assign rsp_is_call       = rsp_ff.is_call;
   assign rsp_is_ret        = rsp_ff.is_ret;

endmodule

`default_nettype wire

>>> rtl/c8d_pair.sv
// Byte pairing stage: joins ROM bytes into opcodes and tracks their addresses.
`default_nettype none

module c8d_pair
   import c8d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rom_byte,
   input  wire logic       req_rom_end,
   input  wire logic       down_open,
   output logic            pair_valid,
   output pair_type        pair
);

   logic [15:0] base_ff, base_in;
   logic [7:0]  held_ff, held_in;
   logic        phase_ff, phase_in;
   logic [15:0] offset_ff, offset_in;
   logic        valid_ff, valid_in;
   pair_type    pair_ff, pair_in;
   logic        accept;

   assign req_stall = valid_ff && !down_open;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      base_in   = csr_wr_en ? csr_wr_data : base_ff;
      held_in   = held_ff;
      phase_in  = phase_ff;
      offset_in = offset_ff;
      pair_in   = pair_ff;
      valid_in  = valid_ff && !down_open;
      if (accept) begin
         if (!phase_ff) begin
            if (req_rom_end) begin
               offset_in = '0;
            end else begin
               held_in  = req_rom_byte;
               phase_in = 1'b1;
            end
         end else begin
            pair_in.opcode  = {held_ff, req_rom_byte};
            pair_in.address = base_ff + offset_ff;
            valid_in        = 1'b1;
            phase_in        = 1'b0;
            offset_in       = req_rom_end ? 16'd0 : offset_ff + OFFSET_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         held_ff   <= '0;
         phase_ff  <= 1'b0;
         offset_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         base_ff   <= base_in;
         held_ff   <= held_in;
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         valid_ff  <= valid_in;
      end
      pair_ff <= pair_in;
   end

   assign pair_valid = valid_ff;
   assign pair       = pair_ff;

endmodule

`default_nettype wire

>>> rtl/c8d_decode.sv
// Opcode decoder: field extraction, instruction kind and control-flow flags.
`default_nettype none

module c8d_decode
   import c8d_pkg::*;
(
   input  wire pair_type pair,
   output decoded_type   dec
);

   logic [15:0] op;
   logic [3:0]  n;
   logic [7:0]  nn;
   logic [5:0]  kind;

   assign op = pair.opcode;
   assign n  = op[3:0];
   assign nn = op[7:0];

   always_comb begin
      kind = KIND_UNKNOWN;
      unique case (op[15:12])
         4'h0: begin
            priority if (op == 16'h00E0) kind = KIND_CLS;
            else if (op == 16'h00EE) kind = KIND_RET;
            else kind = KIND_SYS;
         end
         4'h1: kind = KIND_JP;
         4'h2: kind = KIND_CALL;
         4'h3: kind = KIND_SE_VX_NN;
         4'h4: kind = KIND_SNE_VX_NN;
         4'h5: kind = (n == 4'h0) ? KIND_SE_VX_VY : KIND_UNKNOWN;
         4'h6: kind = KIND_LD_VX_NN;
         4'h7: kind = KIND_ADD_VX_NN;
         4'h8: begin
            unique case (n)
               4'h0:    kind = KIND_LD_VX_VY;
               4'h1:    kind = KIND_OR_VX_VY;
               4'h2:    kind = KIND_AND_VX_VY;
               4'h3:    kind = KIND_XOR_VX_VY;
               4'h4:    kind = KIND_ADD_VX_VY;
               4'h5:    kind = KIND_SUB_VX_VY;
               4'h6:    kind = KIND_SHR_VX;
               4'h7:    kind = KIND_SUBN_VX_VY;
               4'hE:    kind = KIND_SHL_VX;
               default: kind = KIND_UNKNOWN;
            endcase
         end
         4'h9: kind = (n == 4'h0) ? KIND_SNE_VX_VY : KIND_UNKNOWN;
         4'hA: kind = KIND_LD_I_NNN;
         4'hB: kind = KIND_JP_V0;
         4'hC: kind = KIND_RND;
         4'hD: kind = KIND_DRW;
         4'hE: begin
            priority if (nn == 8'h9E) kind = KIND_SKP;
            else if (nn == 8'hA1) kind = KIND_SKNP;
            else kind = KIND_UNKNOWN;
         end
         4'hF: begin
            unique case (nn)
               8'h07:   kind = KIND_LD_VX_DT;
               8'h0A:   kind = KIND_LD_VX_K;
               8'h15:   kind = KIND_LD_DT_VX;
               8'h18:   kind = KIND_LD_ST_VX;
               8'h1E:   kind = KIND_ADD_I_VX;
               8'h29:   kind = KIND_LD_F_VX;
               8'h33:   kind = KIND_LD_B_VX;
               8'h55:   kind = KIND_LD_I_VX;
               8'h65:   kind = KIND_LD_VX_I;
               default: kind = KIND_UNKNOWN;
            endcase
         end
         default: kind = KIND_UNKNOWN;
      endcase
   end

   always_comb begin
      dec.instr_address = pair.address;
      dec.opcode_word   = op;
      dec.reg_x         = op[11:8];
      dec.reg_y         = op[7:4];
      dec.nibble_n      = n;
      dec.byte_nn       = nn;
      dec.addr_nnn      = op[11:0];
      dec.instr_kind    = kind;
      dec.is_jump       = (kind == KIND_JP) || (kind == KIND_JP_V0);
      dec.is_skip       = (kind >= KIND_SE_VX_NN) && (kind <= KIND_SKNP);
      dec.is_call       = (kind == KIND_CALL);
      dec.is_ret        = (kind == KIND_RET);
   end

endmodule

`default_nettype wire

>>> rtl/c8d_checker.sv
// Port-level assertions for the CHIP-8 ROM instruction decoder and their bind.
`default_nettype none

module c8d_checker
   import c8d_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_opcode_word,
   input wire logic [3:0]  rsp_reg_x,
   input wire logic [11:0] rsp_addr_nnn,
   input wire logic [5:0]  rsp_instr_kind,
   input wire logic        rsp_is_jump,
   input wire logic        rsp_is_skip,
   input wire logic        rsp_is_call,
   input wire logic        rsp_is_ret
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result beat valid right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_opcode_word))
      else $error("Stalled result beat changed or vanished.");

   a_fields_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reg_x == rsp_opcode_word[11:8]) &&
                    (rsp_addr_nnn == rsp_opcode_word[11:0]))
      else $error("Opcode fields disagree with the opcode word.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_is_jump, rsp_is_skip, rsp_is_call, rsp_is_ret}) &&
                    (rsp_is_ret == (rsp_instr_kind == KIND_RET)))
      else $error("Control-flow flags are inconsistent.");

   a_jump_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_jump |->
         (rsp_opcode_word[15:12] == 4'h1) || (rsp_opcode_word[15:12] == 4'hB))
      else $error("Jump flag set on a non-jump opcode.");

endmodule

bind chip8_rom_instruction_decoder_top c8d_checker u_c8d_checker (.*);

`default_nettype wire

>>> tb/chip8_rom_instruction_decoder_top_tb.sv
// Self-checking testbench that streams ROM bytes into the CHIP-8 decoder and checks each decoded opcode.
`timescale 1ns / 100ps

module chip8_rom_instruction_decoder_top_tb;
   import c8d_pkg::*;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [3:0] ALU_LD   = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [7:0] NN_SKP      = 8'h9E;
   localparam logic [7:0] NN_SKNP     = 8'hA1;
   localparam logic [7:0] NN_LD_VX_DT = 8'h07;
   localparam logic [7:0] NN_LD_VX_K  = 8'h0A;
   localparam logic [7:0] NN_LD_DT_VX = 8'h15;
   localparam logic [7:0] NN_LD_ST_VX = 8'h18;
   localparam logic [7:0] NN_ADD_I_VX = 8'h1E;
   localparam logic [7:0] NN_LD_F_VX  = 8'h29;
   localparam logic [7:0] NN_LD_B_VX  = 8'h33;
   localparam logic [7:0] NN_LD_I_VX  = 8'h55;
   localparam logic [7:0] NN_LD_VX_I  = 8'h65;

   localparam int RANDOM_BYTES = 1350;

   class rom_scoreboard;
      decoded_type expected_q[$];
      logic [15:0] base_addr = BASE_RESET;
      logic [7:0]  high_byte = '0;
      bit          have_high = 1'b0;
      logic [15:0] offset = '0;
      int          mismatches = 0;

      function logic [5:0] classify(logic [15:0] op);
         logic [5:0] kind;
         kind = KIND_UNKNOWN;
         case (op[15:12])
            4'h0: begin
               if (op == OP_CLS) kind = KIND_CLS;
               else if (op == OP_RET) kind = KIND_RET;
               else kind = KIND_SYS;
            end
            4'h1: kind = KIND_JP;
            4'h2: kind = KIND_CALL;
            4'h3: kind = KIND_SE_VX_NN;
            4'h4: kind = KIND_SNE_VX_NN;
            4'h5: if (op[3:0] == 4'h0) kind = KIND_SE_VX_VY;
            4'h6: kind = KIND_LD_VX_NN;
            4'h7: kind = KIND_ADD_VX_NN;
            4'h8: begin
               case (op[3:0])
                  ALU_LD:   kind = KIND_LD_VX_VY;
                  ALU_OR:   kind = KIND_OR_VX_VY;
                  ALU_AND:  kind = KIND_AND_VX_VY;
                  ALU_XOR:  kind = KIND_XOR_VX_VY;
                  ALU_ADD:  kind = KIND_ADD_VX_VY;
                  ALU_SUB:  kind = KIND_SUB_VX_VY;
                  ALU_SHR:  kind = KIND_SHR_VX;
                  ALU_SUBN: kind = KIND_SUBN_VX_VY;
                  ALU_SHL:  kind = KIND_SHL_VX;
                  default:  kind = KIND_UNKNOWN;
               endcase
            end
            4'h9: if (op[3:0] == 4'h0) kind = KIND_SNE_VX_VY;
            4'hA: kind = KIND_LD_I_NNN;
            4'hB: kind = KIND_JP_V0;
            4'hC: kind = KIND_RND;
            4'hD: kind = KIND_DRW;
            4'hE: begin
               if (op[7:0] == NN_SKP) kind = KIND_SKP;
               else if (op[7:0] == NN_SKNP) kind = KIND_SKNP;
            end
            default: begin
               case (op[7:0])
                  NN_LD_VX_DT: kind = KIND_LD_VX_DT;
                  NN_LD_VX_K:  kind = KIND_LD_VX_K;
                  NN_LD_DT_VX: kind = KIND_LD_DT_VX;
                  NN_LD_ST_VX: kind = KIND_LD_ST_VX;
                  NN_ADD_I_VX: kind = KIND_ADD_I_VX;
                  NN_LD_F_VX:  kind = KIND_LD_F_VX;
                  NN_LD_B_VX:  kind = KIND_LD_B_VX;
                  NN_LD_I_VX:  kind = KIND_LD_I_VX;
                  NN_LD_VX_I:  kind = KIND_LD_VX_I;
                  default:     kind = KIND_UNKNOWN;
               endcase
            end
         endcase
         return kind;
      endfunction

      function void set_base(logic [15:0] value);
         base_addr = value;
      endfunction

      function void note_rom_byte(logic [7:0] b, logic last);
         decoded_type d;
         logic [15:0] op;
         if (!have_high) begin
            if (last) begin
               offset = '0;
            end else begin
               high_byte = b;
               have_high = 1'b1;
            end
            return;
         end
         op = {high_byte, b};
         d.instr_address = base_addr + offset;
         d.opcode_word   = op;
         d.reg_x         = op[11:8];
         d.reg_y         = op[7:4];
         d.nibble_n      = op[3:0];
         d.byte_nn       = op[7:0];
         d.addr_nnn      = op[11:0];
         d.instr_kind    = classify(op);
         d.is_jump       = (d.instr_kind == KIND_JP) || (d.instr_kind == KIND_JP_V0);
         d.is_skip       = (d.instr_kind >= KIND_SE_VX_NN) && (d.instr_kind <= KIND_SKNP);
         d.is_call       = (d.instr_kind == KIND_CALL);
         d.is_ret        = (d.instr_kind == KIND_RET);
         expected_q = {expected_q, d};
         have_high = 1'b0;
         offset = last ? 16'h0000 : offset + OFFSET_STEP;
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH: %s", what);
      endtask

      task check_decoded(decoded_type got);
         decoded_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing expected, opcode %h", got.opcode_word));
            return;
         end
         want = expected_q.pop_front();
         if (got.instr_address !== want.instr_address)
            report($sformatf("instr_address got %h want %h (opcode %h)",
                             got.instr_address, want.instr_address, want.opcode_word));
         if (got.opcode_word !== want.opcode_word)
            report($sformatf("opcode_word got %h want %h", got.opcode_word, want.opcode_word));
         if (got.reg_x !== want.reg_x)
            report($sformatf("reg_x got %h want %h", got.reg_x, want.reg_x));
         if (got.reg_y !== want.reg_y)
            report($sformatf("reg_y got %h want %h", got.reg_y, want.reg_y));
         if (got.nibble_n !== want.nibble_n)
            report($sformatf("nibble_n got %h want %h", got.nibble_n, want.nibble_n));
         if (got.byte_nn !== want.byte_nn)
            report($sformatf("byte_nn got %h want %h", got.byte_nn, want.byte_nn));
         if (got.addr_nnn !== want.addr_nnn)
            report($sformatf("addr_nnn got %h want %h", got.addr_nnn, want.addr_nnn));
         if (got.instr_kind !== want.instr_kind)
            report($sformatf("instr_kind got %0d want %0d (opcode %h)",
                             got.instr_kind, want.instr_kind, want.opcode_word));
         if (got.is_jump !== want.is_jump)
            report($sformatf("is_jump got %b want %b (opcode %h)",
                             got.is_jump, want.is_jump, want.opcode_word));
         if (got.is_skip !== want.is_skip)
            report($sformatf("is_skip got %b want %b (opcode %h)",
                             got.is_skip, want.is_skip, want.opcode_word));
         if (got.is_call !== want.is_call)
            report($sformatf("is_call got %b want %b (opcode %h)",
                             got.is_call, want.is_call, want.opcode_word));
         if (got.is_ret !== want.is_ret)
            report($sformatf("is_ret got %b want %b (opcode %h)",
                             got.is_ret, want.is_ret, want.opcode_word));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rom_byte = '0;
   logic        req_rom_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_instr_address;
   logic [15:0] rsp_opcode_word;
   logic [3:0]  rsp_reg_x;
   logic [3:0]  rsp_reg_y;
   logic [3:0]  rsp_nibble_n;
   logic [7:0]  rsp_byte_nn;
   logic [11:0] rsp_addr_nnn;
   logic [5:0]  rsp_instr_kind;
   logic        rsp_is_jump;
   logic        rsp_is_skip;
   logic        rsp_is_call;
   logic        rsp_is_ret;

   rom_scoreboard book = new;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;
   int          hold_request = 0;
   int          rom_left = 0;
   bit          rom_pos = 1'b0;
   bit          rom_noise = 1'b0;
   logic [15:0] rom_word = '0;

   chip8_rom_instruction_decoder_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rom_byte      (req_rom_byte),
      .req_rom_end       (req_rom_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_instr_address (rsp_instr_address),
      .rsp_opcode_word   (rsp_opcode_word),
      .rsp_reg_x         (rsp_reg_x),
      .rsp_reg_y         (rsp_reg_y),
      .rsp_nibble_n      (rsp_nibble_n),
      .rsp_byte_nn       (rsp_byte_nn),
      .rsp_addr_nnn      (rsp_addr_nnn),
      .rsp_instr_kind    (rsp_instr_kind),
      .rsp_is_jump       (rsp_is_jump),
      .rsp_is_skip       (rsp_is_skip),
      .rsp_is_call       (rsp_is_call),
      .rsp_is_ret        (rsp_is_ret)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] special_nn();
      case ($urandom_range(0, 12))
         0:       return NN_SKP;
         1:       return NN_SKNP;
         2:       return NN_LD_VX_DT;
         3:       return NN_LD_VX_K;
         4:       return NN_LD_DT_VX;
         5:       return NN_LD_ST_VX;
         6:       return NN_ADD_I_VX;
         7:       return NN_LD_F_VX;
         8:       return NN_LD_B_VX;
         9:       return NN_LD_I_VX;
         10:      return NN_LD_VX_I;
         11:      return OP_CLS[7:0];
         default: return OP_RET[7:0];
      endcase
   endfunction

   function automatic logic [15:0] random_opcode();
      logic [15:0] op;
      op = 16'($urandom);
      case ($urandom_range(0, 7))
         0, 1: op[7:0] = special_nn();
         2: op[3:0] = ($urandom_range(0, 1) != 0) ? ALU_SHL : 4'($urandom_range(0, 7));
         3: op[3:0] = 4'h0;
         4: op = ($urandom_range(0, 1) != 0) ? OP_CLS : OP_RET;
         default: ;
      endcase
      return op;
   endfunction

   function automatic logic [15:0] pick_base();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'hFFFE;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_rom_byte <= b;
      req_rom_end  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_rom_byte(b, last);
   endtask

   task automatic send_pair(input logic [15:0] op, input logic last);
      send_byte(op[15:8], 1'b0);
      send_byte(op[7:0], last);
   endtask

   task automatic send_rom_byte();
      logic [7:0] b;
      if (rom_left == 0) begin
         rom_left = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
         rom_noise = ($urandom_range(0, 4) == 0);
         rom_pos = 1'b0;
      end
      if (!rom_pos) begin
         rom_word = rom_noise ? 16'($urandom) : random_opcode();
         b = rom_word[15:8];
      end else begin
         b = rom_word[7:0];
      end
      rom_pos = !rom_pos;
      rom_left--;
      send_byte(b, rom_left == 0);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (book.expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_base(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.set_base(value);
   endtask

   initial begin : result_sink
      int          hold;
      decoded_type got;
      wait (reset == 1'b0);
      forever begin
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end else begin
            hold = rx_quiet ? 0 : $urandom_range(0, 19);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.instr_address = rsp_instr_address;
         got.opcode_word   = rsp_opcode_word;
         got.reg_x         = rsp_reg_x;
         got.reg_y         = rsp_reg_y;
         got.nibble_n      = rsp_nibble_n;
         got.byte_nn       = rsp_byte_nn;
         got.addr_nnn      = rsp_addr_nnn;
         got.instr_kind    = rsp_instr_kind;
         got.is_jump       = rsp_is_jump;
         got.is_skip       = rsp_is_skip;
         got.is_call       = rsp_is_call;
         got.is_ret        = rsp_is_ret;
         book.check_decoded(got);
      end
   end

   initial begin : stimulus
      int  sent;
      int  burst;
      bit  pressure_done;
      sent = 0;
      pressure_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(OP_CLS, 1'b0);
      send_pair(OP_RET, 1'b0);
      send_pair(16'h0000, 1'b0);
      send_pair(16'h1FFF, 1'b0);
      send_pair(16'h2ABC, 1'b0);
      send_pair(16'hB000, 1'b0);
      send_pair(16'h5AB1, 1'b0);
      send_pair(16'h8ABF, 1'b0);
      send_pair(16'hE09E, 1'b0);
      send_pair(16'hFFFF, 1'b0);
      send_byte(8'h12, 1'b1);
      send_pair(16'hD125, 1'b1);
      send_pair(16'h7F00, 1'b0);

      wait_for_idle();
      write_base(16'hFFFF);
      send_pair(16'h3C55, 1'b0);
      send_pair(16'h4001, 1'b1);
      wait_for_idle();
      write_base(16'h0000);
      send_byte(8'hF2, 1'b0);
      wait_for_idle();
      write_base(16'h8000);
      send_byte(8'h65, 1'b1);

      while (sent < RANDOM_BYTES) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            wait_for_idle();
            write_base(pick_base());
         end else if ($urandom_range(0, 4) == 0) begin
            wait_for_idle();
         end
         if (!pressure_done && sent > 400) begin
            hold_request = 300;
            tx_quiet = 1'b1;
            burst = 80;
            pressure_done = 1'b1;
         end else begin
            burst = $urandom_range(4, 60);
         end
         repeat (burst) send_rom_byte();
         sent += burst;
      end

      req_valid <= 1'b0;
      while (book.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (book.mismatches == 0) begin
         $display("chip8_rom_instruction_decoder_top verification clean");
      end else begin
         $display("chip8_rom_instruction_decoder_top verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("chip8_rom_instruction_decoder_top verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/c8d_pkg.sv
rtl/c8d_pair.sv
rtl/c8d_decode.sv
rtl/chip8_rom_instruction_decoder_top.sv
rtl/c8d_checker.sv
tb/chip8_rom_instruction_decoder_top_tb.sv
